### hdl/ilpd_pkg.sv
// ----------------------------------------------------------------------------
// ilpd_pkg
// Shared types and constants of the indexed palette line doubler.
// ----------------------------------------------------------------------------
package ilpd_pkg;

  localparam int OUT_WIDTH     = 640;
  localparam int OUT_HEIGHT    = 480;
  localparam int PALETTE_DEPTH = 256;

  localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int HALF_W = OUT_WIDTH / 2;

  // geometry datapath width: holds OUT_*, twice a frame size and their sums
  localparam int GEO_W = $clog2(OUT_WIDTH + OUT_HEIGHT + 4096) + 1;

  // RGB565 masks and luminance weights
  localparam logic [7:0] R_MASK = 8'hf8;
  localparam logic [7:0] G_MASK = 8'hfc;
  localparam logic [7:0] Y_WR   = 8'd77;
  localparam logic [7:0] Y_WG   = 8'd150;
  localparam logic [7:0] Y_WB   = 8'd29;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_PIXEL = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_CRT_ENABLE   = 2'd2,
    CFG_GREY_ENABLE  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  palette_index;
    logic [23:0] color_in;
    logic [8:0]  out_line;
    logic [9:0]  src_column;
    logic [7:0]  pixel_code;
  } in_t;

  typedef struct packed {
    logic        write_enable;
    logic [8:0]  word_position;
    logic [31:0] pixel_pair;
    logic [9:0]  source_row;
    logic [23:0] read_color;
  } out_t;

  typedef struct packed {
    logic [9:0] frame_width;
    logic [9:0] frame_height;
    logic       crt_enable;
    logic       greyscale_enable;
  } cfg_t;

  typedef struct packed {
    logic       write_enable;
    logic [8:0] word_position;
    logic [9:0] source_row;
  } geom_t;

endpackage

### hdl/indexed_palette_line_doubler.sv
// ----------------------------------------------------------------------------
// indexed_palette_line_doubler
// Palette write/read and indexed pixel conversion for a 2x doubled frame
// centered in the output raster, giving RGB565 pixel pairs.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i, in_stall_o, in_word_i    | to block
//  out     | out_valid_o, out_stall_i, out_word_o | from block
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i     | to block
//
// One word per clock sustained while the output is not stalled; the palette read
// is registered, then the color conversion goes into the output register.
// Palette writes land at the accept edge, so the next word already reads the
// new entry; no interlock is needed.
// Reset clears the valid bits of all 256 entries at once: no clear sweep.
// in_stall_o rises only while the output register is full and stalled.
// ----------------------------------------------------------------------------
module indexed_palette_line_doubler (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ilpd_pkg::in_t   in_word_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ilpd_pkg::out_t  out_word_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [9:0]      cfg_wdata_i
);
  import ilpd_pkg::*;

  cfg_t  cfg_q;
  geom_t geom;
  geom_t s1_geom_q;
  logic  s1_valid_q, s1_in_range_q;
  func_e s1_func_q;
  out_t  out_q, out_d;
  logic  out_valid_q;

  logic              accept, adv_out, in_range, pal_we;
  logic [7:0]        lookup_idx;
  logic [PAL_AW-1:0] raddr;
  logic [23:0]       rdata, lookup_color;
  logic [31:0]       pair;
  func_e             in_func;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width      <= 10'd320;
      cfg_q.frame_height     <= 10'd240;
      cfg_q.crt_enable       <= 1'b0;
      cfg_q.greyscale_enable <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  cfg_q.frame_width      <= cfg_wdata_i;
        CFG_FRAME_HEIGHT: cfg_q.frame_height     <= cfg_wdata_i;
        CFG_CRT_ENABLE:   cfg_q.crt_enable       <= cfg_wdata_i[0];
        CFG_GREY_ENABLE:  cfg_q.greyscale_enable <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign adv_out    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !adv_out;
  assign accept     = in_valid_i && !in_stall_o;

  // stage 0: address the palette, resolve geometry
  assign in_func    = func_e'(in_word_i.func);
  assign lookup_idx = (in_func == FUNC_READ) ? in_word_i.palette_index
                                             : in_word_i.pixel_code;
  assign in_range   = {1'b0, lookup_idx} < 9'(PALETTE_DEPTH);
  assign raddr      = lookup_idx[PAL_AW-1:0];
  assign pal_we     = accept && (in_func == FUNC_WRITE)
                   && ({1'b0, in_word_i.palette_index} < 9'(PALETTE_DEPTH));

  ilpd_palette_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (pal_we),
    .waddr_i (in_word_i.palette_index[PAL_AW-1:0]),
    .wdata_i (in_word_i.color_in),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ilpd_geometry u_geom (
    .cfg_i        (cfg_q),
    .out_line_i   (in_word_i.out_line),
    .src_column_i (in_word_i.src_column),
    .geom_o       (geom)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_func_q     <= in_func;
      s1_in_range_q <= in_range;
      s1_geom_q     <= geom;
    end
  end

  // stage 1: color conversion, result assembly
  assign lookup_color = s1_in_range_q ? rdata : 24'h0;

  ilpd_color u_color (
    .color_i   (lookup_color),
    .grey_en_i (cfg_q.greyscale_enable),
    .pair_o    (pair)
  );

  always_comb begin
    out_d = '0;
    case (s1_func_q)
      FUNC_READ: out_d.read_color = lookup_color;
      FUNC_PIXEL: begin
        if (s1_geom_q.write_enable) begin
          out_d.write_enable  = 1'b1;
          out_d.word_position = s1_geom_q.word_position;
          out_d.pixel_pair    = pair;
          out_d.source_row    = s1_geom_q.source_row;
        end
      end
      default: out_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

### hdl/ilpd_palette_ram.sv
// ----------------------------------------------------------------------------
// ilpd_palette_ram
// Palette store: one write port, one registered read port, per-entry valid
// bits so that never-written entries read as black after reset.
// ----------------------------------------------------------------------------
module ilpd_palette_ram (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [ilpd_pkg::PAL_AW-1:0] waddr_i,
  input  logic [23:0]               wdata_i,
  input  logic                      re_i,
  input  logic [ilpd_pkg::PAL_AW-1:0] raddr_i,
  output logic [23:0]               rdata_o
);
  import ilpd_pkg::*;

  logic [23:0]              mem_q [PALETTE_DEPTH];
  logic [PALETTE_DEPTH-1:0] vld_q;
  logic [23:0]              rdata_q;
  logic                     rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : 24'h0;

endmodule

### hdl/ilpd_geometry.sv
// ----------------------------------------------------------------------------
// ilpd_geometry
// Maps an output line and source column onto the centered, 2x doubled frame:
// framebuffer row, output word position and the write flag.
// ----------------------------------------------------------------------------
module ilpd_geometry (
  input  ilpd_pkg::cfg_t  cfg_i,
  input  logic [8:0]      out_line_i,
  input  logic [9:0]      src_column_i,
  output ilpd_pkg::geom_t geom_o
);
  import ilpd_pkg::*;

  logic [GEO_W-1:0] fw, fh, fw2, fh2, line, col;
  logic             y_neg;
  logic [GEO_W-1:0] y_mag, y_half, d, row;
  logic             above, below, crt_blank;
  logic [GEO_W-1:0] x_off, base, pairs, wpos;
  logic             past_clamp, empty;

  always_comb begin
    fw   = GEO_W'(cfg_i.frame_width);
    fh   = GEO_W'(cfg_i.frame_height);
    fw2  = fw << 1;
    fh2  = fh << 1;
    line = GEO_W'(out_line_i);
    col  = GEO_W'(src_column_i);

    // vertical offset, truncated toward zero: y_off = +-y_half
    y_neg  = fh2 > GEO_W'(OUT_HEIGHT);
    y_mag  = y_neg ? (fh2 - GEO_W'(OUT_HEIGHT)) : (GEO_W'(OUT_HEIGHT) - fh2);
    y_half = y_mag >> 1;
    above  = !y_neg && (line < y_half);
    d      = y_neg ? (line + y_half) : (line - y_half);
    row    = d >> 1;
    below  = row >= fh;
    crt_blank = cfg_i.crt_enable && d[0];

    // horizontal offset clamps at zero
    x_off = (GEO_W'(OUT_WIDTH) > fw2) ? ((GEO_W'(OUT_WIDTH) - fw2) >> 1) : '0;
    base  = x_off >> 1;
    pairs = ((base + fw) > GEO_W'(HALF_W)) ? (GEO_W'(HALF_W) - base) : fw;
    past_clamp = col >= pairs;
    wpos  = base + col;

    empty = (cfg_i.frame_width == 10'd0) || (cfg_i.frame_height == 10'd0);

    geom_o.write_enable  = !(empty || above || below || crt_blank || past_clamp);
    geom_o.word_position = wpos[8:0];
    geom_o.source_row    = row[9:0];
  end

endmodule

### hdl/ilpd_color.sv
// ----------------------------------------------------------------------------
// ilpd_color
// Optional luminance grey, RGB888 to RGB565, and duplication into a word.
// ----------------------------------------------------------------------------
module ilpd_color (
  input  logic [23:0] color_i,
  input  logic        grey_en_i,
  output logic [31:0] pair_o
);
  import ilpd_pkg::*;

  logic [7:0]  r, g, b, y;
  logic [15:0] ysum;
  logic [23:0] c;
  logic [15:0] p;

  always_comb begin
    r    = color_i[23:16];
    g    = color_i[15:8];
    b    = color_i[7:0];
    // max 256*255, fits 16 bits
    ysum = 16'(r * Y_WR) + 16'(g * Y_WG) + 16'(b * Y_WB);
    y    = ysum[15:8];
    c    = grey_en_i ? {y, y, y} : color_i;
    p    = {c[23:16] & R_MASK, 8'h00} | {5'h00, c[15:8] & G_MASK, 3'h0}
         | {11'h000, c[7:3]};
    pair_o = {p, p};
  end

endmodule

### hdl/ilpd_checker.sv
// ----------------------------------------------------------------------------
// ilpd_checker
// Port-level checks of the line doubler, bound to the top level.
// ----------------------------------------------------------------------------
module ilpd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input ilpd_pkg::out_t out_word_o
);
  import ilpd_pkg::*;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  // input is only held off by a blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // an accept leaves out_valid_o high after the stage 1 and output registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> ##1 out_valid_o)
    else $error("output missing two cycles after accept");

  // unwritten pixels carry no position, color or row
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.write_enable |->
      out_word_o.word_position == 9'd0 && out_word_o.pixel_pair == 32'd0
      && out_word_o.source_row == 10'd0)
    else $error("nonzero pixel fields on unwritten word");

endmodule

bind indexed_palette_line_doubler ilpd_checker u_ilpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

### verif/tb_indexed_palette_line_doubler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indexed_palette_line_doubler
// Self-checking bench for the palette line doubler. A shadow palette and
// shadow registers predict each result word from every accepted input word.
// Directed tests cover the frame edges, the blanking modes and unused codes.
// Random traffic then loads the palette and streams pixels under changing
// frame settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_indexed_palette_line_doubler;
  import ilpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_t        in_word_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_t       out_word_o;
  logic       cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i   = CFG_FRAME_WIDTH;
  logic [9:0] cfg_wdata_i = '0;

  // shadow state of the block
  logic [23:0] shadow_palette [PALETTE_DEPTH];
  logic [9:0]  frame_w;
  logic [9:0]  frame_h;
  logic        crt_on;
  logic        grey_on;

  out_t pending_results [$];
  int   mismatches = 0;
  bit   idling_on  = 1'b1;

  indexed_palette_line_doubler i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void frame_geometry(output int y_off, output int base,
                                         output int pairs);
    int x_off;
    y_off = (OUT_HEIGHT - 2 * int'(frame_h)) / 2;
    x_off = (OUT_WIDTH - 2 * int'(frame_w)) / 2;
    if (x_off < 0) x_off = 0;
    base  = x_off / 2;
    pairs = int'(frame_w);
    if (base + pairs > OUT_WIDTH / 2) pairs = OUT_WIDTH / 2 - base;
  endfunction

  function automatic out_t doubler_result(input in_t w);
    out_t        r;
    int          y_off, base, pairs, d, row, lum;
    logic [23:0] c;
    logic [15:0] p;
    r = '0;
    case (func_e'(w.func))
      FUNC_WRITE: begin
        if (int'(w.palette_index) < PALETTE_DEPTH) shadow_palette[w.palette_index] = w.color_in;
      end
      FUNC_READ: begin
        if (int'(w.palette_index) < PALETTE_DEPTH) r.read_color = shadow_palette[w.palette_index];
      end
      FUNC_PIXEL: begin
        frame_geometry(y_off, base, pairs);
        d   = int'(w.out_line) - y_off;
        row = d / 2;
        if (frame_w != 0 && frame_h != 0 && d >= 0 && row < int'(frame_h) &&
            !(crt_on && (d % 2) == 1) && int'(w.src_column) < pairs) begin
          c = (int'(w.pixel_code) < PALETTE_DEPTH) ? shadow_palette[w.pixel_code] : '0;
          if (grey_on) begin
            lum = (77 * int'(c[23:16]) + 150 * int'(c[15:8]) + 29 * int'(c[7:0])) >> 8;
            c   = {3{lum[7:0]}};
          end
          p               = {c[23:19], c[15:10], c[7:3]};
          r.write_enable  = 1'b1;
          r.word_position = 9'(base + int'(w.src_column));
          r.pixel_pair    = {p, p};
          r.source_row    = 10'(row);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, expv, actv);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    out_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, out_word_o);
        mismatches++;
      end else begin
        exp_w = pending_results.pop_front();
        check_field("write_enable", exp_w.write_enable, out_word_o.write_enable);
        check_field("word_position", exp_w.word_position, out_word_o.word_position);
        check_field("pixel_pair", exp_w.pixel_pair, out_word_o.pixel_pair);
        check_field("source_row", exp_w.source_row, out_word_o.source_row);
        check_field("read_color", exp_w.read_color, out_word_o.read_color);
      end
    end
  end

  // output side stalls in bursts
  initial begin : out_stall_gen
    int unsigned stall_len;
    forever begin
      @(negedge clk_i);
      if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_len = $urandom_range(1, 17);
        out_stall_i <= 1'b1;
        repeat (stall_len) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb_indexed_palette_line_doubler failed");
    $finish;
  end

  // ---------------------------------------------------------------- driving

  task automatic send_word(input in_t w);
    int unsigned gap;
    logic [63:0] junk;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap  = $urandom_range(1, 17);
      junk = {$urandom, $urandom};
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      in_word_i  <= junk[$bits(in_t)-1:0];
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(doubler_result(w));
  endtask

  // sender pauses until every outstanding word has come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [9:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_config(input logic [9:0] fw, input logic [9:0] fh,
                            input logic crt, input logic grey);
    drain_results();
    write_reg(CFG_FRAME_WIDTH, fw);
    write_reg(CFG_FRAME_HEIGHT, fh);
    write_reg(CFG_CRT_ENABLE, {9'd0, crt});
    write_reg(CFG_GREY_ENABLE, {9'd0, grey});
    frame_w = fw;
    frame_h = fh;
    crt_on  = crt;
    grey_on = grey;
  endtask

  function automatic in_t make_word(input func_e f, input logic [7:0] idx,
                                    input logic [23:0] color, input logic [8:0] line,
                                    input logic [9:0] col, input logic [7:0] code);
    in_t w;
    w.func          = f;
    w.palette_index = idx;
    w.color_in      = color;
    w.out_line      = line;
    w.src_column    = col;
    w.pixel_code    = code;
    return w;
  endfunction

  // well-formed pixels mostly land inside the frame and the column clamp
  task automatic send_random_word(input int pixel_share);
    int unsigned pick;
    int          y_off, base, pairs, lo, hi;
    in_t         w;
    pick = $urandom_range(0, 99);
    w    = make_word(FUNC_PIXEL, 8'($urandom), 24'($urandom), 9'($urandom_range(0, 479)),
                     10'($urandom), 8'($urandom));
    if (pick < pixel_share) begin
      frame_geometry(y_off, base, pairs);
      lo = (y_off < 0) ? 0 : y_off;
      hi = y_off + 2 * int'(frame_h) - 1;
      if (hi > 479) hi = 479;
      if (lo <= hi && $urandom_range(0, 4) != 0) w.out_line = 9'($urandom_range(lo, hi));
      if (pairs > 0 && $urandom_range(0, 4) != 0)
        w.src_column = 10'($urandom_range(0, pairs - 1));
    end else if (pick < pixel_share + (100 - pixel_share) / 2) begin
      w.func = FUNC_WRITE;
    end else if (pick < 97) begin
      w.func = FUNC_READ;
    end else begin
      w.func = FUNC_NONE;
    end
    send_word(w);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    send_word(make_word(FUNC_READ, 8'd0, 24'h0, 9'd0, 10'd0, 8'd0));
    send_word(make_word(FUNC_READ, 8'd255, 24'hffffff, 9'd0, 10'd0, 8'd0));
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd0, 10'd0, 8'd0));
  endtask

  task automatic test_palette_extremes();
    send_word(make_word(FUNC_WRITE, 8'd255, 24'hffffff, 9'd0, 10'd0, 8'd0));
    send_word(make_word(FUNC_READ, 8'd255, 24'h0, 9'd0, 10'd0, 8'd0));
    send_word(make_word(FUNC_WRITE, 8'd0, 24'h84c1a7, 9'd0, 10'd0, 8'd0));
    send_word(make_word(FUNC_READ, 8'd0, 24'h0, 9'd0, 10'd0, 8'd0));
    send_word(make_word(FUNC_NONE, 8'hff, 24'hffffff, 9'd479, 10'h3ff, 8'hff));
    // last word of the last line, then one column past the clamp
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd479, 10'd319, 8'd255));
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd479, 10'd320, 8'd255));
  endtask

  // 300x200 frame: y_off 40, base 10, 300 columns
  task automatic test_frame_edges();
    set_config(10'd300, 10'd200, 1'b0, 1'b0);
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd39, 10'd0, 8'd0));
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd40, 10'd0, 8'd0));
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd439, 10'd299, 8'd255));
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd440, 10'd0, 8'd0));
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd100, 10'd300, 8'd0));
  endtask

  task automatic test_crt_grey();
    set_config(10'd300, 10'd200, 1'b1, 1'b1);
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd40, 10'd5, 8'd0));
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd41, 10'd5, 8'd0));
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd42, 10'd6, 8'd255));
  endtask

  task automatic test_size_extremes();
    set_config(10'd0, 10'd240, 1'b0, 1'b0);
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd10, 10'd0, 8'd0));
    set_config(10'd320, 10'd0, 1'b0, 1'b0);
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd10, 10'd0, 8'd0));
    // oversize frame: no border, columns clamp at the output width
    set_config(10'd1023, 10'd1023, 1'b0, 1'b0);
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd0, 10'd319, 8'd255));
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd479, 10'd320, 8'd255));
    // single pixel frame at the center
    set_config(10'd1, 10'd1, 1'b0, 1'b1);
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd239, 10'd0, 8'd0));
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd240, 10'd0, 8'd255));
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd241, 10'd0, 8'd0));
    send_word(make_word(FUNC_PIXEL, 8'd0, 24'h0, 9'd239, 10'd1, 8'd0));
  endtask

  task automatic test_random_traffic();
    logic [9:0] fw, fh;
    set_config(10'd320, 10'd240, 1'b0, 1'b0);
    for (int i = 0; i < PALETTE_DEPTH; i++)
      send_word(make_word(FUNC_WRITE, 8'(i), 24'($urandom), 9'($urandom_range(0, 479)),
                          10'($urandom), 8'($urandom)));
    for (int i = 0; i < 380; i++) begin
      if (i % 50 == 0) idling_on = ($urandom_range(0, 3) != 0);
      if (i % 95 == 94) begin
        fw = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(321, 1023))
                                          : 10'($urandom_range(1, 320));
        fh = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(241, 1023))
                                          : 10'($urandom_range(1, 240));
        set_config(fw, fh, 1'($urandom), 1'($urandom));
      end
      if (i == 200) drain_results();
      send_random_word(80);
    end
  endtask

  task automatic test_full_rate();
    set_config(10'd256, 10'd192, 1'b0, 1'b1);
    idling_on = 1'b0;
    for (int i = 0; i < 60; i++) send_random_word(85);
  endtask

  initial begin : main
    for (int i = 0; i < PALETTE_DEPTH; i++) shadow_palette[i] = '0;
    frame_w = 10'd320;
    frame_h = 10'd240;
    crt_on  = 1'b0;
    grey_on = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_palette_extremes();
    test_frame_edges();
    test_crt_grey();
    test_size_extremes();
    test_random_traffic();
    test_full_rate();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb_indexed_palette_line_doubler passed");
    else
      $display("tb_indexed_palette_line_doubler failed");
    $finish;
  end

endmodule
